// File: src/integer_to_ascii_radix_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for integer_to_ascii_radix_top
// Clocked assertion shorthands; every failure reports through $error.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_MACROS_SVH

// Property checked only while out of reset
`define I2A_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included
`define I2A_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/i2a_pkg.sv
// ---------------------------------------------------------------------------
// i2a_pkg
// Types, codes and constants shared by the integer-to-ASCII radix converter.
// ---------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

  localparam int IN_VALUE_W     = 32;
  localparam int BASE_W         = 5;
  localparam int CHAR_W         = 8;
  localparam int DIGIT_W        = 4;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int RESULT_CAP     = 32;

  // Quotient bits resolved per cycle by the divider
  localparam int STEP_BITS      = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [BASE_W-1:0]  BASE_MIN  = 5'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX  = 5'd16;
  localparam logic [BASE_W-1:0]  BASE_DEC  = 5'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic                  command;
    logic [IN_VALUE_W-1:0] value;
    logic [BASE_W-1:0]     base;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              empty_res;
    logic              last;
  } result_t;

  // Classification handed from the front end to the converter
  typedef struct packed {
    logic              invalid;
    logic              negative;
    logic [BASE_W-1:0] base;
  } job_ctrl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_DIGIT,
    B_FETCH,
    B_SIGN,
    B_SHOW,
    B_EMPTY
  } back_state_t;

endpackage

`default_nettype wire

// File: src/i2a_front.sv
// ---------------------------------------------------------------------------
// i2a_front
// Accepts input words, checks the base and forms the magnitude to convert.
// ---------------------------------------------------------------------------
`default_nettype none

module i2a_front
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire item_t                 item,
  input  wire logic                  full,
  output logic                       push,
  output job_ctrl_t                  ctrl,
  output logic [VALUE_BITS-1:0]      mag
);

  localparam int EXT_W = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

  logic [EXT_W-1:0]      ext;
  logic [VALUE_BITS-1:0] raw;
  logic                  invalid;
  logic                  negative;

  assign ext = EXT_W'(item.value);
  assign raw = ext[VALUE_BITS-1:0];

  assign invalid  = (item.base < BASE_MIN) || (item.base > BASE_MAX);
  // Only decimal shows a sign; other bases print the raw bit pattern
  assign negative = !invalid && (item.command == CMD_SIGNED) &&
                    (item.base == BASE_DEC) && raw[VALUE_BITS-1];

  assign ctrl.invalid  = invalid;
  assign ctrl.negative = negative;
  assign ctrl.base     = item.base;
  assign mag           = negative ? (~raw + 1'b1) : raw;

  assign item_stall = full;
  assign push       = item_valid && !full;

endmodule

`default_nettype wire

// File: src/i2a_queue.sv
// ---------------------------------------------------------------------------
// i2a_queue
// Short FIFO of classified jobs between the front end and the converter.
// ---------------------------------------------------------------------------
`default_nettype none

module i2a_queue
  import i2a_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/i2a_back.sv
// ---------------------------------------------------------------------------
// i2a_back
// Divides the magnitude down digit by digit into the digit store, then
// streams the characters out most significant first, or one empty word for a bad base.
// ---------------------------------------------------------------------------
`default_nettype none

module i2a_back
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  job_valid,
  input  wire job_ctrl_t             job_ctrl,
  input  wire logic [VALUE_BITS-1:0] job_mag,
  output logic                       job_pop,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result
);

  localparam int CHUNKS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W   = CHUNKS * STEP_BITS;
  localparam int CH_W    = $clog2(CHUNKS + 1);
  localparam int AW      = $clog2(MAX_DIGITS);
  localparam int N_W     = $clog2(MAX_DIGITS + 1);
  localparam int LIM_POS = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;
  localparam int LIM_NEG = (MAX_DIGITS < RESULT_CAP - 1) ? MAX_DIGITS : RESULT_CAP - 1;

  back_state_t        state;
  back_state_t        state_next;

  logic [PAD_W-1:0]   quot;
  logic [DIGIT_W-1:0] rem;
  logic [CH_W-1:0]    chunk;
  logic [N_W-1:0]     n;
  logic [AW-1:0]      idx;
  logic               neg;
  logic [BASE_W-1:0]  base;
  logic [DIGIT_W-1:0] rd_data;
  logic [DIGIT_W-1:0] store [MAX_DIGITS];

  logic               out_valid;
  result_t            out_data;

  logic [PAD_W-1:0]   q_step;
  logic [DIGIT_W-1:0] r_step;
  logic [DIGIT_W:0]   part;
  logic               qbit;

  logic               out_free;
  logic               chunk_end;
  logic               quot_zero;
  logic [N_W-1:0]     limit;
  logic               keep_digit;
  logic [N_W-1:0]     n_m1;

  logic               load_out;
  result_t            out_next;
  logic               mem_we;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_TEN) begin
      return CH_ZERO + CHAR_W'(d);
    end else begin
      return CH_A + CHAR_W'(d - DIGIT_TEN);
    end
  endfunction

  // One restoring-division slice: STEP_BITS quotient bits per cycle
  always_comb begin
    q_step = quot;
    r_step = rem;
    part   = '0;
    qbit   = 1'b0;
    for (int k = 0; k < STEP_BITS; k++) begin
      part   = {r_step, q_step[PAD_W-1]};
      qbit   = (part >= base);
      r_step = qbit ? DIGIT_W'(part - base) : part[DIGIT_W-1:0];
      q_step = {q_step[PAD_W-2:0], qbit};
    end
  end

  assign out_free   = !out_valid || !result_stall;
  assign chunk_end  = (chunk == CH_W'(CHUNKS - 1));
  assign quot_zero  = (quot == '0);
  assign limit      = neg ? N_W'(LIM_NEG) : N_W'(LIM_POS);
  assign keep_digit = (n < limit);
  assign n_m1       = n - 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          state_next = job_ctrl.invalid ? B_EMPTY : B_DIV;
        end
      end
      B_DIV: begin
        if (chunk_end) begin
          state_next = B_DIGIT;
        end
      end
      B_DIGIT: begin
        state_next = quot_zero ? B_FETCH : B_DIV;
      end
      B_FETCH: begin
        state_next = neg ? B_SIGN : B_SHOW;
      end
      B_SIGN: begin
        if (out_free) begin
          state_next = B_SHOW;
        end
      end
      B_SHOW: begin
        if (out_free && (idx == '0)) begin
          state_next = B_IDLE;
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    job_pop  = 1'b0;
    load_out = 1'b0;
    out_next = '{character: CH_NUL, empty_res: 1'b0, last: 1'b0};
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = n_m1[AW-1:0];
    case (state)
      B_IDLE: begin
        job_pop = job_valid;
      end
      B_DIGIT: begin
        mem_we = keep_digit;
      end
      B_FETCH: begin
        rd_en = 1'b1;
      end
      B_SIGN: begin
        load_out = out_free;
        out_next = '{character: CH_MINUS, empty_res: 1'b0, last: 1'b0};
      end
      B_SHOW: begin
        load_out = out_free;
        out_next = '{character: to_char(rd_data), empty_res: 1'b0, last: (idx == '0)};
        // Prefetch the next lower digit while this one goes out
        rd_en    = out_free && (idx != '0);
        rd_addr  = idx - 1'b1;
      end
      B_EMPTY: begin
        load_out = out_free;
        out_next = '{character: CH_NUL, empty_res: 1'b1, last: 1'b1};
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      n         <= '0;
      quot      <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            quot <= PAD_W'(job_mag);
            n    <= '0;
          end
        end
        B_DIV: begin
          quot <= q_step;
        end
        B_DIGIT: begin
          if (keep_digit) begin
            n <= n + 1'b1;
          end
        end
        default: begin
          quot <= quot;
        end
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        neg   <= job_ctrl.negative;
        base  <= job_ctrl.base;
        rem   <= '0;
        chunk <= '0;
      end
      B_DIV: begin
        rem   <= r_step;
        chunk <= chunk + 1'b1;
      end
      B_DIGIT: begin
        rem   <= '0;
        chunk <= '0;
      end
      B_FETCH: begin
        idx <= n_m1[AW-1:0];
      end
      B_SHOW: begin
        if (out_free && (idx != '0)) begin
          idx <= idx - 1'b1;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
    if (load_out) begin
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[n[AW-1:0]] <= rem;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  assign result_valid = out_valid;
  assign result       = out_data;

endmodule

`default_nettype wire

// File: src/integer_to_ascii_radix_top.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Integer to ASCII string conversion in radix 2 to 16, one character per
// output word, most significant digit first.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------
//   item     | in        | item_valid/stall     | command, value, base
//   result   | out       | result_valid/stall   | character, empty_res, last
//
// Each digit is divided out by the 8-bit-a-cycle remainder chain of the
// divider in i2a_back and then written to the digit store.
// Reset clears the queue, the converter state and the output register; the
// digit store needs no clearing. A two-entry queue takes new words while a
// stalled output holds its character.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_top
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam int ENTRY_W = $bits(job_ctrl_t) + VALUE_BITS;

  logic                  push;
  logic                  full;
  job_ctrl_t             front_ctrl;
  logic [VALUE_BITS-1:0] front_mag;
  logic                  pop;
  logic                  head_valid;
  logic [ENTRY_W-1:0]    head_data;
  job_ctrl_t             job_ctrl;
  logic [VALUE_BITS-1:0] job_mag;

  i2a_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .full       (full),
    .push       (push),
    .ctrl       (front_ctrl),
    .mag        (front_mag)
  );

  i2a_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({front_ctrl, front_mag}),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign job_ctrl = job_ctrl_t'(head_data[ENTRY_W-1:VALUE_BITS]);
  assign job_mag  = head_data[VALUE_BITS-1:0];

  i2a_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (head_valid),
    .job_ctrl     (job_ctrl),
    .job_mag      (job_mag),
    .job_pop      (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: src/i2a_checker.sv
// ---------------------------------------------------------------------------
// i2a_checker
// Port-level checks on the character stream of the radix converter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_radix_top_macros.svh"

module i2a_checker
  import i2a_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // Output register comes out of reset empty
  `I2A_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result valid after reset")

  // Hold a stalled word
  `I2A_ASSERT(a_stall_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

  // A bad base gives a single closing word
  `I2A_ASSERT(a_empty_last, clk, rst, result_valid && result.empty_res |-> result.last && (result.character == CH_NUL), "empty result malformed")

  // Only a sign or a lower-case digit may appear
  `I2A_ASSERT(a_legal_char, clk, rst, result_valid && !result.empty_res |-> (result.character == CH_MINUS) || (result.character >= CH_ZERO && result.character <= CH_NINE) || (result.character >= CH_A && result.character <= CH_F), "illegal character")

  // A sign always has a digit after it
  `I2A_ASSERT(a_sign_not_last, clk, rst, result_valid && !result.empty_res && (result.character == CH_MINUS) |-> !result.last, "sign marked last")

endmodule

bind integer_to_ascii_radix_top i2a_checker u_i2a_checker (.*);

`default_nettype wire

// File: tb/sv/tb_integer_to_ascii_radix_top.sv
// ---------------------------------------------------------------------------
// tb_integer_to_ascii_radix_top
// Feeds conversion words (command, value, base) to the radix converter and
// scores every returned character against a digit-by-digit prediction kept
// in step with the accepted words. Directed corner values come first, then
// random traffic under sender bursts, receiver stalls and a long hold-off.
// ---------------------------------------------------------------------------

module tb_integer_to_ascii_radix_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  integer_to_ascii_radix_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: digits of the last valid conversion
  logic [DIGIT_W-1:0]    stored_digits [MAX_DIGITS_DEF];
  int unsigned           digit_total   = 0;
  logic [IN_VALUE_W-1:0] quotient_left = '0;

  result_t awaited_chars [$];

  int fail_count     = 0;
  int words_sent     = 0;
  int chars_checked  = 0;
  int bad_base_items = 0;
  int minus_items    = 0;
  int input_stalls   = 0;

  // Sender pacing
  int max_gap   = 0;
  int max_burst = 1;
  int burst_left = 0;

  // Receiver pattern
  int stall_pct = 0;
  int stall_run = 0;
  int hold_req  = 0;
  int hold_left = 0;

  // Push the characters that one accepted word must produce
  function automatic void spell_number(input item_t it);
    logic [IN_VALUE_W-1:0] mag;
    logic                  negative;
    int unsigned           limit;
    logic [DIGIT_W-1:0]    d;
    if (it.base < BASE_MIN || it.base > BASE_MAX) begin
      awaited_chars.push_back('{character: CH_NUL, empty_res: 1'b1, last: 1'b1});
      bad_base_items++;
      return;
    end
    negative = (it.command == CMD_SIGNED) && (it.base == BASE_DEC) &&
               it.value[IN_VALUE_W-1];
    mag = negative ? -it.value : it.value;
    limit = negative ? RESULT_CAP - 1 : RESULT_CAP;
    if (limit > MAX_DIGITS_DEF) limit = MAX_DIGITS_DEF;
    quotient_left = mag;
    digit_total = 0;
    do begin
      d = DIGIT_W'(quotient_left % it.base);
      quotient_left = quotient_left / it.base;
      // keep the least significant digits, drop the rest
      if (digit_total < limit) begin
        stored_digits[digit_total] = d;
        digit_total++;
      end
    end while (quotient_left != 0);
    if (negative) begin
      awaited_chars.push_back('{character: CH_MINUS, empty_res: 1'b0, last: 1'b0});
      minus_items++;
    end
    for (int i = digit_total; i > 0; i--) begin
      d = stored_digits[i-1];
      awaited_chars.push_back('{
        character: (d < DIGIT_TEN) ? CH_ZERO + d : CH_A + (d - DIGIT_TEN),
        empty_res: 1'b0,
        last:      (i == 1)
      });
    end
  endfunction

  function automatic logic [IN_VALUE_W-1:0] pick_value();
    logic [IN_VALUE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0: v = v >> $urandom_range(1, 31);
      1: v = $urandom_range(0, 40);
      2: v = v | 32'h8000_0000;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 4) == 0) return BASE_DEC;
      return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
    end
    if ($urandom_range(0, 1) != 0) return BASE_W'($urandom_range(17, 31));
    return BASE_W'($urandom_range(0, 1));
  endfunction

  task automatic note_failure(input string what, input result_t got, input result_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch (%s): got char %h empty %b last %b, want char %h empty %b last %b",
               $realtime, what, got.character, got.empty_res, got.last,
               want.character, want.empty_res, want.last);
  endtask

  // Offer one word; valid stays high into the next word unless a gap falls
  task automatic send_item(input logic cmd, input logic [IN_VALUE_W-1:0] v,
                           input logic [BASE_W-1:0] b);
    int gap;
    item_t it;
    it = '{command: cmd, value: v, base: b};
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, max_burst);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    spell_number(it);
    words_sent++;
    burst_left--;
  endtask

  // Pause the sender until every awaited character has arrived
  task automatic drain_results();
    item_valid <= 1'b0;
    burst_left = 0;
    while (awaited_chars.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++)
      send_item(1'($urandom_range(0, 1)), pick_value(), pick_base());
  endtask

  // Receiver: a hold-off, else short stall runs at the current density
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_run = $urandom_range(0, 5);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (item_valid && item_stall) input_stalls++;
      if (result_valid && !result_stall) begin
        chars_checked++;
        if (awaited_chars.size() == 0) begin
          note_failure("nothing awaited", result, '0);
        end else begin
          want = awaited_chars.pop_front();
          if (result.character !== want.character)
            note_failure("character", result, want);
          else if (result.empty_res !== want.empty_res)
            note_failure("empty_res", result, want);
          else if (result.last !== want.last)
            note_failure("last", result, want);
        end
      end
    end
  end

  task automatic test_directed();
    max_gap = 2; max_burst = 4; stall_pct = 10;
    send_item(CMD_UNSIGNED, 32'h0000_0000, BASE_DEC);
    send_item(CMD_SIGNED,   32'h0000_0000, BASE_MIN);
    send_item(CMD_UNSIGNED, 32'hffff_ffff, BASE_MIN);
    send_item(CMD_SIGNED,   32'hffff_ffff, BASE_MIN);
    send_item(CMD_UNSIGNED, 32'hffff_ffff, BASE_DEC);
    send_item(CMD_SIGNED,   32'hffff_ffff, BASE_DEC);
    send_item(CMD_SIGNED,   32'h8000_0000, BASE_DEC);
    send_item(CMD_SIGNED,   32'h7fff_ffff, BASE_DEC);
    send_item(CMD_SIGNED,   32'h8000_0000, BASE_MAX);
    send_item(CMD_UNSIGNED, 32'hffff_ffff, BASE_MAX);
    send_item(CMD_UNSIGNED, 32'h00ab_cdef, BASE_MAX);
    send_item(CMD_UNSIGNED, 32'hffff_ffff, 5'd3);
    send_item(CMD_SIGNED,   32'hffff_fff6, 5'd8);
    send_item(CMD_UNSIGNED, 32'h0000_00ee, 5'd15);
    send_item(CMD_UNSIGNED, 32'h0000_0009, BASE_DEC);
    send_item(CMD_SIGNED,   32'hffff_fff6, BASE_DEC);
    send_item(CMD_SIGNED,   32'h1234_5678, 5'd0);
    send_item(CMD_UNSIGNED, 32'hffff_ffff, 5'd1);
    send_item(CMD_SIGNED,   32'h8000_0000, 5'd17);
    send_item(CMD_UNSIGNED, 32'h0000_0000, 5'd31);
    send_item(CMD_UNSIGNED, 32'h0000_0001, BASE_MIN);
    drain_results();
  endtask

  task automatic test_random_mixed_idle();
    max_gap = 6; max_burst = 10; stall_pct = 25;
    run_random(110);
    drain_results();
  endtask

  task automatic test_random_heavy_stall();
    max_gap = 12; max_burst = 3; stall_pct = 70;
    run_random(100);
    drain_results();
  endtask

  task automatic test_back_to_back();
    max_gap = 0; max_burst = 1; stall_pct = 0;
    run_random(100);
    drain_results();
  endtask

  // Hold the receiver off while words keep coming, so the input stalls
  task automatic test_backpressure_hold();
    max_gap = 0; max_burst = 1; stall_pct = 15;
    hold_req = 600;
    run_random(24);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mixed_idle();
    test_random_heavy_stall();
    test_back_to_back();
    test_backpressure_hold();
    while (awaited_chars.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    while (awaited_chars.size() != 0) begin
      note_failure("never arrived", '0, awaited_chars.pop_front());
    end
    $display("Converted %0d words into %0d characters: %0d with a bad base, %0d negative decimal.",
             words_sent, chars_checked, bad_base_items, minus_items);
    $display("Input held back for %0d cycles; %0d mismatches in total.",
             input_stalls, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d characters outstanding.", awaited_chars.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/i2a_pkg.sv
src/i2a_front.sv
src/i2a_queue.sv
src/i2a_back.sv
src/integer_to_ascii_radix_top.sv
src/i2a_checker.sv
tb/sv/tb_integer_to_ascii_radix_top.sv
